// ===== rtl/wsdf_pkg.sv =====
// Package for the frame deframer: phase encoding, header constants and the result type.
// Depends on nothing; used by wsdf_skid and websocket_frame_deframer.
`default_nettype none

package wsdf_pkg;

    typedef enum logic [2:0] {
        PH_B0  = 3'd0,
        PH_B1  = 3'd1,
        PH_EXT = 3'd2,
        PH_KEY = 3'd3,
        PH_PAY = 3'd4
    } phase_t;

    localparam logic [6:0] LEN16_CODE   = 7'd126;
    localparam logic [6:0] LEN64_CODE   = 7'd127;
    localparam logic [3:0] EXT16_BYTES  = 4'd2;
    localparam logic [3:0] EXT64_BYTES  = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;
    localparam logic       KIND_HEADER  = 1'b0;
    localparam logic       KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic        length_error;
        logic [7:0]  data_byte;
        logic [62:0] payload_length;
        logic        masked;
        logic [3:0]  opcode;
        logic [2:0]  rsv;
        logic        fin;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// A result is registered in the output stage before it appears on m_tvalid.
// Throughput: one input request per cycle, sustained while the result side keeps up; the
// two-entry output stage holds one more result while the first waits to be taken.
// Reset (rst_n, asynchronous, active low) returns the parser to the first header byte
// and empties the output stage. Depends on wsdf_pkg and wsdf_skid.
`default_nettype none

module websocket_frame_deframer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  wire         m_tready,
    // fin, rsv[2:0], opcode[3:0], masked, payload_length[62:0], data_byte[7:0],
    // length_error, seven zero bits
    output logic [87:0] m_tdata,
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);
    import wsdf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic [2:0]  rsv_reg, rsv_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [62:0] len_reg, len_next;
    logic [62:0] rem_reg, rem_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  keypos_reg, keypos_next;
    logic        err_reg, err_next;

    logic        in_fire;
    logic        res_valid;
    logic        res_kind;
    logic        res_last;
    logic [7:0]  res_data;
    logic        finish;
    logic [7:0]  ext_byte;
    logic [7:0]  key_byte;
    result_t     res;
    result_t     out_res;

    assign in_fire = s_tvalid & s_tready;

    always_comb
    begin
        case (keypos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        rsv_next    = rsv_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        keypos_next = keypos_reg;
        err_next    = err_reg;
        res_valid   = 1'b0;
        res_kind    = KIND_HEADER;
        res_last    = 1'b0;
        res_data    = 8'd0;
        finish      = 1'b0;
        ext_byte    = s_tdata;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_B1:
                begin
                    masked_next = s_tdata[7];
                    len_next    = '0;
                    if (s_tdata[6:0] == LEN16_CODE)
                    begin
                        phase_next = PH_EXT;
                        cnt_next   = EXT16_BYTES;
                    end
                    else if (s_tdata[6:0] == LEN64_CODE)
                    begin
                        phase_next = PH_EXT;
                        cnt_next   = EXT64_BYTES;
                    end
                    else
                    begin
                        len_next = {56'd0, s_tdata[6:0]};
                        if (masked_next)
                        begin
                            phase_next = PH_KEY;
                            cnt_next   = KEY_BYTES;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                end
                PH_EXT:
                begin
                    // A set top bit in the long length is flagged and its whole byte is shifted in as zero.
                    if (cnt_reg == EXT64_BYTES && s_tdata[7])
                    begin
                        err_next = 1'b1;
                        ext_byte = 8'd0;
                    end
                    len_next = {len_reg[54:0], ext_byte};
                    if (cnt_reg != 4'd0)
                    begin
                        cnt_next = cnt_reg - 4'd1;
                    end
                    if (cnt_next == 4'd0)
                    begin
                        if (masked_reg)
                        begin
                            phase_next = PH_KEY;
                            cnt_next   = KEY_BYTES;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], s_tdata};
                    if (cnt_reg != 4'd0)
                    begin
                        cnt_next = cnt_reg - 4'd1;
                    end
                    if (cnt_next == 4'd0)
                    begin
                        finish = 1'b1;
                    end
                end
                PH_PAY:
                begin
                    res_data    = masked_reg ? (s_tdata ^ key_byte) : s_tdata;
                    keypos_next = keypos_reg + 2'd1;
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - 63'd1;
                    end
                    res_valid = 1'b1;
                    res_kind  = KIND_PAYLOAD;
                    if (rem_next == '0)
                    begin
                        phase_next = PH_B0;
                        res_last   = 1'b1;
                    end
                end
                default:
                begin
                    fin_next    = s_tdata[7];
                    rsv_next    = s_tdata[6:4];
                    opcode_next = s_tdata[3:0];
                    masked_next = 1'b0;
                    err_next    = 1'b0;
                    len_next    = '0;
                    cnt_next    = 4'd0;
                    phase_next  = PH_B1;
                end
            endcase

            if (finish)
            begin
                rem_next    = len_next;
                keypos_next = 2'd0;
                res_valid   = 1'b1;
                res_kind    = KIND_HEADER;
                if (len_next == '0)
                begin
                    phase_next = PH_B0;
                    res_last   = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAY;
                end
            end
        end

        res.kind           = res_kind;
        res.last           = res_last;
        res.length_error   = err_next;
        res.data_byte      = res_data;
        res.payload_length = len_next;
        res.masked         = masked_next;
        res.opcode         = opcode_next;
        res.rsv            = rsv_next;
        res.fin            = fin_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_B0;
            cnt_reg    <= 4'd0;
            fin_reg    <= 1'b0;
            rsv_reg    <= 3'd0;
            opcode_reg <= 4'd0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            rem_reg    <= '0;
            key_reg    <= 32'd0;
            keypos_reg <= 2'd0;
            err_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            rsv_reg    <= rsv_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            keypos_reg <= keypos_next;
            err_reg    <= err_next;
        end
    end

    wsdf_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {7'd0, out_res.length_error, out_res.data_byte, out_res.payload_length,
                      out_res.masked, out_res.opcode, out_res.rsv, out_res.fin};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== rtl/wsdf_skid.sv =====
// Two-entry output stage that decouples the parser from the result consumer.
// Depends on wsdf_pkg for the result type.
`default_nettype none

module wsdf_skid (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire wsdf_pkg::result_t push_data,
    output logic             ready,
    output logic             out_valid,
    input  wire              out_ready,
    output wsdf_pkg::result_t out_data
);
    import wsdf_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop       = out_valid_reg & out_ready;
    assign ready     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !pop)
        begin
            if (push)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire
